[rtl/min_heap_priority_queue_defines.svh]
// Assertion macros shared by the queue's checker
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mhpq_pkg.sv]
// Types, constants and codes of the min-heap priority queue
`default_nettype none

package mhpq_pkg;

  // Sizing
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KID_W    = ADDR_W + 2;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 9;

  // Operation codes
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] pay;
  } entry_t;

  // Heap store access: one write port, two read ports
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } ram_req_t;

  // Compare unit operands
  typedef struct packed {
    logic [KEY_W-1:0] mov_key;
    logic [KEY_W-1:0] left_key;
    logic [KEY_W-1:0] right_key;
    logic             left_ok;
    logic             right_ok;
  } cmp_req_t;

  typedef struct packed {
    logic move;
    logic pick_right;
  } cmp_res_t;

endpackage

`default_nettype wire

[rtl/mhpq_ram.sv]
// Heap store: entry memory with one write port and two registered read ports
`default_nettype none

module mhpq_ram
  import mhpq_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output entry_t        rdata_a,
  output entry_t        rdata_b
);

  entry_t mem [CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read two entries, registered
  always_ff @(posedge clk) begin
    rdata_a <= mem[req.raddr_a];
    rdata_b <= mem[req.raddr_b];
  end

endmodule

`default_nettype wire

[rtl/mhpq_cmp.sv]
// Shared key compare unit: decides whether the moving entry gives way and to which child
`default_nettype none

module mhpq_cmp
  import mhpq_pkg::*;
(
  input  wire cmp_req_t req,
  output cmp_res_t      res
);

  logic             l_less;
  logic [KEY_W-1:0] best_key;
  logic             r_less;

  // Left wins a tie with the right: right must be strictly smaller than the best so far
  always_comb begin
    l_less         = req.left_ok && (req.left_key < req.mov_key);
    best_key       = l_less ? req.left_key : req.mov_key;
    r_less         = req.right_ok && (req.right_key < best_key);
    res.move       = l_less || r_less;
    res.pick_right = r_less;
  end

endmodule

`default_nettype wire

[rtl/mhpq_ctrl.sv]
// Sequencer: walks the heap one level per pass and holds the result register
`default_nettype none

module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [KEY_W-1:0]  freq_key,
  input  wire logic [PAY_W-1:0]  payload,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [KEY_W-1:0]       out_key,
  output logic [PAY_W-1:0]       out_payload,
  output logic [CNT_W-1:0]       count,
  output ram_req_t               ram_req,
  input  wire entry_t            rdata_a,
  input  wire entry_t            rdata_b,
  output cmp_req_t               cmp_req,
  input  wire cmp_res_t          cmp_res
);

  state_t            state, state_next;
  logic [ADDR_W-1:0] pos, pos_next;
  entry_t            mov, mov_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  status_t           res_status, res_status_next;
  entry_t            res_entry, res_entry_next;
  logic              out_valid_next;
  status_t           out_status, out_status_next;
  entry_t            out_entry, out_entry_next;
  logic [CNT_W-1:0]  out_cnt, out_cnt_next;

  logic [ADDR_W-1:0] par;
  logic [KID_W-1:0]  kid_l;
  logic [KID_W-1:0]  kid_r;
  logic [KID_W-1:0]  cnt_ext;
  logic              l_ok;
  logic              r_ok;

  // Heap index arithmetic
  always_comb begin
    par     = (pos - ADDR_W'(1)) >> 1;
    kid_l   = {1'b0, pos, 1'b1};
    kid_r   = {(KID_W - 1)'({1'b0, pos} + (ADDR_W + 1)'(1)), 1'b0};
    cnt_ext = KID_W'(cnt);
    l_ok    = kid_l < cnt_ext;
    r_ok    = kid_r < cnt_ext;
  end

  // State and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
    pos        <= pos_next;
    mov        <= mov_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
    out_status <= out_status_next;
    out_entry  <= out_entry_next;
    out_cnt    <= out_cnt_next;
  end

  // Next state, memory requests and compare operands
  always_comb begin
    state_next      = state;
    pos_next        = pos;
    mov_next        = mov;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    out_valid_next  = out_valid && out_stall;
    out_status_next = out_status;
    out_entry_next  = out_entry;
    out_cnt_next    = out_cnt;

    ram_req.we      = 1'b0;
    ram_req.waddr   = pos;
    ram_req.wdata   = mov;
    ram_req.raddr_a = kid_l[ADDR_W-1:0];
    ram_req.raddr_b = kid_r[ADDR_W-1:0];

    cmp_req.mov_key   = mov.key;
    cmp_req.left_key  = rdata_a.key;
    cmp_req.right_key = rdata_b.key;
    cmp_req.left_ok   = 1'b1;
    cmp_req.right_ok  = 1'b0;

    in_stall = (state != S_IDLE);

    case (state)
      S_IDLE: begin
        res_entry_next  = '0;
        ram_req.raddr_a = '0;
        ram_req.raddr_b = ADDR_W'(cnt - CNT_W'(1));
        if (in_valid) begin
          if (mode == MODE_INSERT) begin
            if (cnt == CNT_W'(CAPACITY)) begin
              res_status_next = ST_FULL;
              state_next      = S_DONE;
            end else begin
              mov_next   = '{key: freq_key, pay: payload};
              pos_next   = cnt[ADDR_W-1:0];
              cnt_next   = cnt + CNT_W'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (cnt == '0) begin
              res_status_next = ST_EMPTY;
              state_next      = S_DONE;
            end else begin
              state_next = S_DN_LOAD;
            end
          end
        end
      end

      // Sift up: fetch the parent, or settle at the root
      S_UP_RD: begin
        ram_req.raddr_a = par;
        if (pos == '0) begin
          ram_req.we      = 1'b1;
          res_status_next = ST_INSERTED;
          state_next      = S_DONE;
        end else begin
          state_next = S_UP_CMP;
        end
      end

      // Sift up: pull the parent down while the moving key is strictly smaller, or settle here
      S_UP_CMP: begin
        cmp_req.mov_key  = rdata_a.key;
        cmp_req.left_key = mov.key;
        if (cmp_res.move) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = rdata_a;
          pos_next      = par;
          state_next    = S_UP_RD;
        end else begin
          ram_req.we      = 1'b1;
          res_status_next = ST_INSERTED;
          state_next      = S_DONE;
        end
      end

      // Extract: take the root, lift the last entry
      S_DN_LOAD: begin
        res_entry_next  = rdata_a;
        mov_next        = rdata_b;
        cnt_next        = cnt - CNT_W'(1);
        pos_next        = '0;
        res_status_next = ST_EXTRACTED;
        state_next      = S_DN_RD;
      end

      // Sift down: fetch both children, or settle at a leaf
      S_DN_RD: begin
        if (l_ok) begin
          state_next = S_DN_CMP;
        end else begin
          ram_req.we = 1'b1;
          state_next = S_DONE;
        end
      end

      // Sift down: raise the smaller child, or settle here
      S_DN_CMP: begin
        cmp_req.right_ok = r_ok;
        ram_req.we       = 1'b1;
        if (cmp_res.move) begin
          ram_req.wdata = cmp_res.pick_right ? rdata_b : rdata_a;
          pos_next      = cmp_res.pick_right ? kid_r[ADDR_W-1:0] : kid_l[ADDR_W-1:0];
          state_next    = S_DN_RD;
        end else begin
          state_next = S_DONE;
        end
      end

      // Hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_entry_next  = res_entry;
          out_cnt_next    = cnt;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    status      = out_status;
    out_key     = out_entry.key;
    out_payload = out_entry.pay;
    count       = out_cnt;
  end

endmodule

`default_nettype wire

[rtl/min_heap_priority_queue.sv]
// Binary min-heap priority queue of (key, payload) entries held in one on-chip memory.
// An insert climbs one heap level per pass through S_UP_RD and S_UP_CMP and settles at the
// root or below a parent whose key is not larger; it climbs at most log2 of the capacity
// levels, eight for 256 entries. An extract takes the root and lifts the last entry in
// S_DN_LOAD, then sinks one level per pass through S_DN_RD and S_DN_CMP until it settles at
// a leaf or above children whose keys are not smaller. A rejected insert on a full heap or
// an extract on an empty one goes straight to the result. The per-level cost is one
// registered memory read followed by one pass through the shared key compare unit. The
// input is stalled while a request is being worked and while its result waits for a stalled
// output register; the input is free again as soon as the result appears, while that result
// may still wait in the output register. A result carries the status, the extracted entry
// (zero unless extracted) and the entry count after the request.
`default_nettype none

module min_heap_priority_queue
  import mhpq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [KEY_W-1:0]  freq_key,
  input  wire logic [PAY_W-1:0]  payload,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [KEY_W-1:0]       out_key,
  output logic [PAY_W-1:0]       out_payload,
  output logic [CNT_W-1:0]       count
);

  ram_req_t ram_req;
  entry_t   rdata_a;
  entry_t   rdata_b;
  cmp_req_t cmp_req;
  cmp_res_t cmp_res;

  mhpq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  mhpq_cmp u_cmp (
    .req (cmp_req),
    .res (cmp_res)
  );

  mhpq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .freq_key    (freq_key),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_key     (out_key),
    .out_payload (out_payload),
    .count       (count),
    .ram_req     (ram_req),
    .rdata_a     (rdata_a),
    .rdata_b     (rdata_b),
    .cmp_req     (cmp_req),
    .cmp_res     (cmp_res)
  );

endmodule

`default_nettype wire

[rtl/mhpq_checker.sv]
// Port-level checks of the queue's results, bound to the top level
`default_nettype none

`include "min_heap_priority_queue_defines.svh"

module mhpq_checker
  import mhpq_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       status,
  input wire logic [KEY_W-1:0] out_key,
  input wire logic [PAY_W-1:0] out_payload,
  input wire logic [CNT_W-1:0] count
);

  // Hold a stalled result
  `MHPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(out_key) && $stable(out_payload) && $stable(count), "stalled result changed")

  // An empty report leaves nothing held
  `MHPQ_ASSERT_NOW(a_empty_cnt, out_valid && status == ST_EMPTY, count == '0 && out_key == '0 && out_payload == '0, "empty report with entries or data")

  // A full report only at capacity
  `MHPQ_ASSERT_NOW(a_full_cnt, out_valid && status == ST_FULL, count == CNT_W'(CAPACITY) && out_key == '0 && out_payload == '0, "full report below capacity")

  // An accepted insert leaves at least one entry and returns no data
  `MHPQ_ASSERT_NOW(a_ins_data, out_valid && status == ST_INSERTED, count != '0 && out_key == '0 && out_payload == '0, "insert result malformed")

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .out_key     (out_key),
  .out_payload (out_payload),
  .count       (count)
);

`default_nettype wire
